### sv/utbc_pkg.sv
`default_nettype none

package utbc_pkg;

    // Pipeline depth, from input register to output register
    localparam int STG_N = 8;

    // Accepted UTC range of the input seconds
    localparam logic [32:0] EPOCH_MIN = 33'd946684800;
    localparam logic [32:0] EPOCH_MAX = 33'd4102444799;

    // Local time is counted from 2000-01-01 00:00:00; years 2000..2099 span REL_LIM seconds
    localparam logic signed [34:0] REL_BASE = 35'sd946684800;
    localparam logic [31:0]        REL_LIM  = 32'd3155760000;

    // Day split: seconds >> 7, then divide by 675 through a reciprocal (exact below 2^25)
    localparam logic [16:0] SECS_DAY   = 17'd86400;
    localparam logic [25:0] RECIP_D675 = 26'd50903317;

    // Hour and minute split
    localparam logic [11:0] SECS_HOUR   = 12'd3600;
    localparam logic [17:0] RECIP_D3600 = 18'd149131;
    localparam logic [12:0] RECIP_D60   = 13'd4370;
    localparam logic [5:0]  SECS_MIN    = 6'd60;

    // Days are rebased to 1996-03-01: four-year blocks end on a leap day
    localparam logic [15:0] DAY_SHIFT   = 16'd1401;
    localparam logic [10:0] DAYS_QUAD   = 11'd1461;
    localparam logic [16:0] RECIP_D1461 = 17'd91868;
    localparam logic [8:0]  DAYS_YEAR   = 9'd365;

    // Weekday: day 0 (2000-01-01) is a Saturday
    localparam logic [15:0] WDAY_SHIFT = 16'd6;
    localparam logic [16:0] RECIP_D7   = 17'd74899;
    localparam logic [2:0]  DAYS_WEEK  = 3'd7;

    // Time of day, rebased day counts and reject flag after the split
    typedef struct packed {
        logic        bad;
        logic [16:0] tod;
        logic [15:0] z;
        logic [15:0] wdx;
    } t_split;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] min;
        logic [5:0] sec;
    } t_hms;

    typedef struct packed {
        logic       bad;
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [2:0] wday;
    } t_ymd;

    // First day of each month in a year that starts on March 1
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] s;
        case (mp)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

    // Month index (0 = March) of a day of year
    function automatic logic [3:0] month_of(input logic [8:0] doy);
        logic [3:0] mp;
        mp = 4'd0;
        for (int i = 1; i < 12; i++) begin
            if (doy >= month_start(4'(i))) begin
                mp = 4'(i);
            end
        end
        return mp;
    endfunction

    // Two BCD digits of a value below 100
    function automatic logic [7:0] bcd2(input logic [6:0] v);
        logic [14:0] p;
        logic [3:0]  q;
        logic [6:0]  r;
        p = 15'(v) * 15'd205;
        q = p[14:11];
        r = v - 7'(q) * 7'd10;
        return {q, r[3:0]};
    endfunction

endpackage

`default_nettype wire

### sv/utbc_if.sv
`default_nettype none

interface utbc_in_if;
    logic               valid;
    logic               ready;
    logic [32:0]        epoch_seconds;
    logic signed [15:0] zone_offset_minutes;

    modport source (output valid, output epoch_seconds, output zone_offset_minutes,
                    input ready);
    modport sink   (input valid, input epoch_seconds, input zone_offset_minutes,
                    output ready);
endinterface

interface utbc_out_if;
    logic       valid;
    logic       ready;
    logic       status;
    logic [6:0] secs_bcd;
    logic [6:0] mins_bcd;
    logic [5:0] hrs_bcd;
    logic [6:0] weekday_onehot;
    logic [5:0] day_bcd;
    logic [4:0] month_bcd;
    logic [7:0] year_bcd;

    modport source (output valid, output status, output secs_bcd, output mins_bcd,
                    output hrs_bcd, output weekday_onehot, output day_bcd,
                    output month_bcd, output year_bcd, input ready);
    modport sink   (input valid, input status, input secs_bcd, input mins_bcd,
                    input hrs_bcd, input weekday_onehot, input day_bcd,
                    input month_bcd, input year_bcd, output ready);
endinterface

`default_nettype wire

### sv/utbc_ctrl.sv
`default_nettype none

module utbc_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic                       i_out_ready,
    output logic [utbc_pkg::STG_N-1:0]      o_en,
    output logic                            o_in_ready,
    output logic                            o_out_valid
);

    logic [utbc_pkg::STG_N-1:0] r_vld;

    // A stage loads when it is empty or its successor loads
    always_comb begin
        o_en[utbc_pkg::STG_N-1] = !r_vld[utbc_pkg::STG_N-1] || i_out_ready;
        for (int k = utbc_pkg::STG_N - 2; k >= 0; k--) begin
            o_en[k] = !r_vld[k] || o_en[k+1];
        end
    end

    assign o_in_ready  = o_en[0];
    assign o_out_valid = r_vld[utbc_pkg::STG_N-1];

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (o_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < utbc_pkg::STG_N; k++) begin
                if (o_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

endmodule

`default_nettype wire

### sv/utbc_split.sv
`default_nettype none

module utbc_split (
    input  wire logic               i_clk,
    input  wire logic [2:0]         i_en,
    input  wire logic [32:0]        i_epoch,
    input  wire logic signed [15:0] i_zone,
    output utbc_pkg::t_split        o_sp
);

    localparam logic signed [34:0] REL_BASE_S = utbc_pkg::REL_BASE;

    logic signed [34:0] w_zext;
    logic signed [34:0] n_rel;
    logic               n_bad_ep;
    logic signed [34:0] r1_rel;
    logic               r1_bad_ep;

    logic               n_bad;
    logic [50:0]        w_dprod;
    logic               r2_bad;
    logic [31:0]        r2_rel;
    logic [15:0]        r2_days;

    logic [32:0]        w_dsec;
    logic [31:0]        w_tod;
    utbc_pkg::t_split   n_sp;
    utbc_pkg::t_split   r3_sp;

    // Stage 1: apply the offset, rebase to 2000-01-01 and check the epoch range
    always_comb begin
        w_zext   = $signed({{19{i_zone[15]}}, i_zone});
        n_rel    = $signed({2'b00, i_epoch}) + (w_zext <<< 6) - (w_zext <<< 2) - REL_BASE_S;
        n_bad_ep = (i_epoch < utbc_pkg::EPOCH_MIN) || (i_epoch > utbc_pkg::EPOCH_MAX);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_rel    <= n_rel;
            r1_bad_ep <= n_bad_ep;
        end
    end

    // Stage 2: check the local year range and take the day count
    always_comb begin
        n_bad   = r1_bad_ep || r1_rel[34] ||
                  (r1_rel[33:0] >= {2'b00, utbc_pkg::REL_LIM});
        w_dprod = 51'(r1_rel[31:7]) * 51'(utbc_pkg::RECIP_D675);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_bad  <= n_bad;
            r2_rel  <= r1_rel[31:0];
            r2_days <= w_dprod[50:35];
        end
    end

    // Stage 3: time of day and rebased day counts
    always_comb begin
        w_dsec    = 33'(r2_days) * 33'(utbc_pkg::SECS_DAY);
        w_tod     = r2_rel - w_dsec[31:0];
        n_sp.bad  = r2_bad;
        n_sp.tod  = w_tod[16:0];
        n_sp.z    = r2_days + utbc_pkg::DAY_SHIFT;
        n_sp.wdx  = r2_days + utbc_pkg::WDAY_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_sp <= n_sp;
        end
    end

    assign o_sp = r3_sp;

endmodule

`default_nettype wire

### sv/utbc_clock.sv
`default_nettype none

module utbc_clock (
    input  wire logic         i_clk,
    input  wire logic [3:0]   i_en,
    input  wire logic [16:0]  i_tod,
    output utbc_pkg::t_hms    o_hms
);

    logic [34:0]    w_hprod;
    logic [16:0]    r4_tod;
    logic [4:0]     r4_hour;

    logic [16:0]    w_hsec;
    logic [16:0]    w_remh;
    logic [11:0]    r5_remh;
    logic [4:0]     r5_hour;

    logic [24:0]    w_mprod;
    logic [11:0]    r6_remh;
    logic [5:0]     r6_min;
    logic [4:0]     r6_hour;

    logic [11:0]    w_msec;
    logic [11:0]    w_sec;
    utbc_pkg::t_hms r7_hms;

    // Stage 4: hour estimate by reciprocal
    assign w_hprod = 35'(i_tod) * 35'(utbc_pkg::RECIP_D3600);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r4_tod  <= i_tod;
            r4_hour <= w_hprod[33:29];
        end
    end

    // Stage 5: seconds left in the hour
    always_comb begin
        w_hsec = 17'(r4_hour) * 17'(utbc_pkg::SECS_HOUR);
        w_remh = r4_tod - w_hsec;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r5_remh <= w_remh[11:0];
            r5_hour <= r4_hour;
        end
    end

    // Stage 6: minute by reciprocal
    assign w_mprod = 25'(r5_remh) * 25'(utbc_pkg::RECIP_D60);

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r6_remh <= r5_remh;
            r6_min  <= w_mprod[23:18];
            r6_hour <= r5_hour;
        end
    end

    // Stage 7: seconds left in the minute
    always_comb begin
        w_msec = 12'(r6_min) * 12'(utbc_pkg::SECS_MIN);
        w_sec  = r6_remh - w_msec;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r7_hms.hour <= r6_hour;
            r7_hms.min  <= r6_min;
            r7_hms.sec  <= w_sec[5:0];
        end
    end

    assign o_hms = r7_hms;

endmodule

`default_nettype wire

### sv/utbc_cal.sv
`default_nettype none

module utbc_cal (
    input  wire logic         i_clk,
    input  wire logic [3:0]   i_en,
    input  wire logic         i_bad,
    input  wire logic [15:0]  i_z,
    input  wire logic [15:0]  i_wdx,
    output utbc_pkg::t_ymd    o_ymd
);

    logic [32:0]    w_qprod;
    logic [32:0]    w_wprod;
    logic           r4_bad;
    logic [15:0]    r4_z;
    logic [4:0]     r4_q4;
    logic [15:0]    r4_wdx;
    logic [12:0]    r4_wq;

    logic [15:0]    w_qday;
    logic [15:0]    w_r4;
    logic [15:0]    w_wday;
    logic [15:0]    w_wd;
    logic           r5_bad;
    logic [10:0]    r5_r4;
    logic [4:0]     r5_q4;
    logic [2:0]     r5_wd;

    logic [1:0]     w_yoe;
    logic [10:0]    w_doy;
    logic           r6_bad;
    logic [8:0]     r6_doy;
    logic [6:0]     r6_ysum;
    logic [2:0]     r6_wd;

    logic [3:0]     w_mp;
    logic [8:0]     w_dom;
    utbc_pkg::t_ymd n_ymd;
    utbc_pkg::t_ymd r7_ymd;

    // Stage 4: four-year block and week estimates by reciprocal
    always_comb begin
        w_qprod = 33'(i_z) * 33'(utbc_pkg::RECIP_D1461);
        w_wprod = 33'(i_wdx) * 33'(utbc_pkg::RECIP_D7);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r4_bad <= i_bad;
            r4_z   <= i_z;
            r4_q4  <= w_qprod[31:27];
            r4_wdx <= i_wdx;
            r4_wq  <= w_wprod[31:19];
        end
    end

    // Stage 5: day within the block, weekday
    always_comb begin
        w_qday = 16'(r4_q4) * 16'(utbc_pkg::DAYS_QUAD);
        w_r4   = r4_z - w_qday;
        w_wday = 16'(r4_wq) * 16'(utbc_pkg::DAYS_WEEK);
        w_wd   = r4_wdx - w_wday;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r5_bad <= r4_bad;
            r5_r4  <= w_r4[10:0];
            r5_q4  <= r4_q4;
            r5_wd  <= w_wd[2:0];
        end
    end

    // Stage 6: year within the block (the leap day closes the block)
    always_comb begin
        if (r5_r4 >= 11'd1095) begin
            w_yoe = 2'd3;
        end else if (r5_r4 >= 11'd730) begin
            w_yoe = 2'd2;
        end else if (r5_r4 >= 11'd365) begin
            w_yoe = 2'd1;
        end else begin
            w_yoe = 2'd0;
        end
        w_doy = r5_r4 - 11'(w_yoe) * 11'(utbc_pkg::DAYS_YEAR);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r6_bad  <= r5_bad;
            r6_doy  <= w_doy[8:0];
            r6_ysum <= {r5_q4, 2'b00} + 7'(w_yoe);
            r6_wd   <= r5_wd;
        end
    end

    // Stage 7: month and day; January and February belong to the next year
    always_comb begin
        w_mp        = utbc_pkg::month_of(r6_doy);
        w_dom       = r6_doy - utbc_pkg::month_start(w_mp) + 9'd1;
        n_ymd.bad   = r6_bad;
        n_ymd.day   = w_dom[4:0];
        n_ymd.wday  = r6_wd;
        if (w_mp < 4'd10) begin
            n_ymd.month = w_mp + 4'd3;
            n_ymd.year  = r6_ysum - 7'd4;
        end else begin
            n_ymd.month = w_mp - 4'd9;
            n_ymd.year  = r6_ysum - 7'd3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r7_ymd <= n_ymd;
        end
    end

    assign o_ymd = r7_ymd;

endmodule

`default_nettype wire

### sv/unix_time_to_bcd_calendar.sv
`default_nettype none

// Channel  Dir  Payload
// i_in     in   epoch_seconds[32:0], zone_offset_minutes[15:0] signed
// o_out    out  status, second/minute/hour/day/month/year BCD, weekday_onehot[6:0]
//
// Eight register stages; one item per cycle unless o_out stalls.
// The depth is set by the chain of reciprocal multiplies (day, hour, minute, block, week).
// Reset clears only the stage valid bits; the datapath has no state between items.
// Each stage holds while full and its successor holds, so a stall on o_out fills
// bubbles first and then backs up to i_in.ready without dropping or repeating items.

module unix_time_to_bcd_calendar (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    utbc_in_if.sink      i_in,
    utbc_out_if.source   o_out
);

    logic [utbc_pkg::STG_N-1:0] w_en;
    logic                       w_out_valid;
    utbc_pkg::t_split           w_sp;
    utbc_pkg::t_hms             w_hms;
    utbc_pkg::t_ymd             w_ymd;

    logic                       r_status;
    logic [6:0]                 r_sec;
    logic [6:0]                 r_min;
    logic [5:0]                 r_hour;
    logic [6:0]                 r_wday;
    logic [5:0]                 r_day;
    logic [4:0]                 r_month;
    logic [7:0]                 r_year;

    logic [7:0]                 n_sec;
    logic [7:0]                 n_min;
    logic [7:0]                 n_hour;
    logic [7:0]                 n_day;
    logic [7:0]                 n_month;
    logic [7:0]                 n_year;
    logic [6:0]                 n_wday;

    utbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_en        (w_en),
        .o_in_ready  (i_in.ready),
        .o_out_valid (w_out_valid)
    );

    utbc_split u_split (
        .i_clk   (i_clk),
        .i_en    (w_en[2:0]),
        .i_epoch (i_in.epoch_seconds),
        .i_zone  (i_in.zone_offset_minutes),
        .o_sp    (w_sp)
    );

    utbc_clock u_clock (
        .i_clk (i_clk),
        .i_en  (w_en[6:3]),
        .i_tod (w_sp.tod),
        .o_hms (w_hms)
    );

    utbc_cal u_cal (
        .i_clk (i_clk),
        .i_en  (w_en[6:3]),
        .i_bad (w_sp.bad),
        .i_z   (w_sp.z),
        .i_wdx (w_sp.wdx),
        .o_ymd (w_ymd)
    );

    // Output stage: BCD digits and weekday mask, zero on a rejected input
    always_comb begin
        n_sec   = utbc_pkg::bcd2(7'(w_hms.sec));
        n_min   = utbc_pkg::bcd2(7'(w_hms.min));
        n_hour  = utbc_pkg::bcd2(7'(w_hms.hour));
        n_day   = utbc_pkg::bcd2(7'(w_ymd.day));
        n_month = utbc_pkg::bcd2(7'(w_ymd.month));
        n_year  = utbc_pkg::bcd2(w_ymd.year);
        n_wday  = 7'b1 << w_ymd.wday;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[utbc_pkg::STG_N-1]) begin
            r_status <= w_ymd.bad;
            if (w_ymd.bad) begin
                r_sec   <= '0;
                r_min   <= '0;
                r_hour  <= '0;
                r_wday  <= '0;
                r_day   <= '0;
                r_month <= '0;
                r_year  <= '0;
            end else begin
                r_sec   <= n_sec[6:0];
                r_min   <= n_min[6:0];
                r_hour  <= n_hour[5:0];
                r_wday  <= n_wday;
                r_day   <= n_day[5:0];
                r_month <= n_month[4:0];
                r_year  <= n_year;
            end
        end
    end

    assign o_out.valid          = w_out_valid;
    assign o_out.status         = r_status;
    assign o_out.secs_bcd       = r_sec;
    assign o_out.mins_bcd       = r_min;
    assign o_out.hrs_bcd        = r_hour;
    assign o_out.weekday_onehot = r_wday;
    assign o_out.day_bcd        = r_day;
    assign o_out.month_bcd      = r_month;
    assign o_out.year_bcd       = r_year;

endmodule

`default_nettype wire
